// ----- design/rpas_pkg.sv -----
package rpas_pkg;

   localparam int ACTORS_DEF = 1024;
   localparam int COUNT_BITS_DEF = 24;
   localparam int ID_BITS = 10;
   localparam int TIME_BITS = 32;
   localparam int SCORE_BITS = 18;
   localparam int FRAC_BITS = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic sampled;
      logic control;
      logic [TIME_BITS-1:0] event_time;
      logic [ID_BITS-1:0] sender_id;
      logic [ID_BITS-1:0] target_id;
   } req_type;

   typedef struct packed {
      logic [SCORE_BITS-1:0] score;
      logic bad_denominator;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_OUTPUT
   } back_state_type;

endpackage

// ----- design/rpas_front.sv -----
// Front: accepts requests, reduces ids modulo ACTORS, queues them.
module rpas_front #(
   parameter int ACTORS = rpas_pkg::ACTORS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  rpas_pkg::req_type req_data,
   output logic q_valid,
   input  logic q_take,
   output rpas_pkg::req_type q_data
);
   localparam int DEPTH = rpas_pkg::QUEUE_DEPTH;
   localparam int PW = $clog2(DEPTH);
   // reciprocal for the id fold; exact for every id below 2^ID_BITS
   localparam int RK = rpas_pkg::ID_BITS + $clog2(ACTORS);
   localparam int RM = ((1 << RK) + ACTORS - 1) / ACTORS;

   rpas_pkg::req_type mem_ff [DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0] cnt_ff, cnt_in;
   rpas_pkg::req_type norm;
   logic push;

   function automatic logic [rpas_pkg::ID_BITS-1:0] fold(
      input logic [rpas_pkg::ID_BITS-1:0] id);
      logic [31:0] quo;
      logic [31:0] rem;
      quo = (32'(id) * 32'(RM)) >> RK;
      rem = 32'(id) - quo * 32'(ACTORS);
      return rpas_pkg::ID_BITS'(rem);
   endfunction

   always_comb begin
      norm = req_data;
      norm.sender_id = fold(req_data.sender_id);
      norm.target_id = fold(req_data.target_id);
   end

   assign req_stall = (cnt_ff == (PW+1)'(DEPTH));
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != '0);
   assign q_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = q_take ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(q_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= norm;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(DEPTH)) else $error("queue overfill");
   a_take: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid) else $error("take from empty queue");
   a_push: assert property (@(posedge clock) disable iff (reset)
      push && !q_take |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
endmodule

// ----- design/rpas_back.sv -----
// Back: count tables, score division, result register.
module rpas_back #(
   parameter int ACTORS = rpas_pkg::ACTORS_DEF,
   parameter int COUNT_BITS = rpas_pkg::COUNT_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_take,
   input  rpas_pkg::req_type q_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rpas_pkg::rsp_type rsp_data
);
   localparam int AW = (ACTORS > 1) ? $clog2(ACTORS) : 1;
   localparam int NB = COUNT_BITS + 1 + rpas_pkg::FRAC_BITS;
   localparam int DB = COUNT_BITS + 1;
   localparam int SW = rpas_pkg::SCORE_BITS;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   logic [COUNT_BITS-1:0] out_mem [ACTORS];
   logic [COUNT_BITS-1:0] in_mem [ACTORS];

   rpas_pkg::back_state_type st_ff, st_in;
   logic [AW:0] clr_ff, clr_in;
   rpas_pkg::req_type cur_ff;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [rpas_pkg::TIME_BITS-1:0] ltime_ff;
   logic [AW-1:0] lsnd_ff, ltgt_ff;
   logic have_ff;
   logic rd_phase_ff, rd_phase_in;
   logic [COUNT_BITS-1:0] o_rd_ff, i_rd_ff, os_rd_ff;
   logic eq_ff, have_snap_ff, lsnd_hit_ff, ltgt_hit_ff;
   logic [COUNT_BITS-1:0] tot_snap_ff;
   logic [NB-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [DB:0] den_ff;
   logic [$clog2(NB+1)-1:0] bit_ff, bit_in;
   logic bad_ff;
   rpas_pkg::rsp_type rsp_ff, rsp_in;
   logic rv_ff, rv_in;
   logic start, do_upd, finish;
   logic [COUNT_BITS-1:0] o_adj, i_adj;
   logic [COUNT_BITS:0] sum;
   logic [DB:0] den_c;
   logic [NB:0] trial;
   logic [AW-1:0] tgt, snd;
   logic [AW-1:0] cur_snd, cur_tgt;

   assign tgt = AW'(q_data.target_id);
   assign snd = AW'(q_data.sender_id);
   assign cur_snd = AW'(cur_ff.sender_id);
   assign cur_tgt = AW'(cur_ff.target_id);

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         rpas_pkg::ST_CLEAR: if (clr_ff == (AW+1)'(ACTORS - 1)) st_in = rpas_pkg::ST_IDLE;
         rpas_pkg::ST_IDLE: if (q_valid && !rd_phase_ff) st_in = rpas_pkg::ST_IDLE;
            else if (rd_phase_ff) st_in = rpas_pkg::ST_DIVIDE;
         rpas_pkg::ST_DIVIDE: if (bit_ff == '0) st_in = rpas_pkg::ST_OUTPUT;
         rpas_pkg::ST_OUTPUT: if (!rv_ff) st_in = rpas_pkg::ST_IDLE;
         default: st_in = rpas_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      start = (st_ff == rpas_pkg::ST_IDLE) && q_valid && !rd_phase_ff;
      rd_phase_in = start;
      do_upd = rd_phase_ff && !cur_ff.control;
      q_take = rd_phase_ff;
      clr_in = (st_ff == rpas_pkg::ST_CLEAR) ? clr_ff + 1'b1 : clr_ff;
      finish = (st_ff == rpas_pkg::ST_OUTPUT) && !rv_ff;
      rv_in = rv_ff && rsp_stall ? 1'b1 : finish ? cur_ff.sampled : 1'b0;
      rsp_in = rsp_ff;
      if (finish) begin
         rsp_in.bad_denominator = bad_ff;
         rsp_in.score = bad_ff ? '0 : (|quo_ff[NB-1:SW]) ? '1 : quo_ff[SW-1:0];
      end
      total_in = (do_upd && total_ff != CMAX) ? total_ff + 1'b1 : total_ff;
      o_adj = (eq_ff && have_snap_ff && lsnd_hit_ff && o_rd_ff != '0) ? o_rd_ff - 1'b1 : o_rd_ff;
      i_adj = (eq_ff && have_snap_ff && ltgt_hit_ff && i_rd_ff != '0) ? i_rd_ff - 1'b1 : i_rd_ff;
      sum = {1'b0, o_adj} + {1'b0, i_adj};
      den_c = eq_ff ? ({2'b0, tot_snap_ff} - 1'b1) : {2'b0, tot_snap_ff};
      trial = {rem_ff, quo_ff[NB-1]} - {{(NB-DB-1){1'b0}}, den_ff, 1'b0};
      rem_in = rem_ff;
      quo_in = quo_ff;
      bit_in = bit_ff;
      if (rd_phase_ff) begin
         rem_in = '0;
         quo_in = {sum, {rpas_pkg::FRAC_BITS{1'b0}}};
         bit_in = ($bits(bit_ff))'(NB);
      end else if (st_ff == rpas_pkg::ST_DIVIDE && bit_ff != '0) begin
         if (!trial[NB]) begin
            rem_in = trial[NB-1:0];
            quo_in = {quo_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[NB-2:0], quo_ff[NB-1]};
            quo_in = {quo_ff[NB-2:0], 1'b0};
         end
         bit_in = bit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= rpas_pkg::ST_CLEAR;
         clr_ff <= '0;
         rd_phase_ff <= 1'b0;
         rv_ff <= 1'b0;
         total_ff <= '0;
         ltime_ff <= '0;
         lsnd_ff <= '0;
         ltgt_ff <= '0;
         have_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         rd_phase_ff <= rd_phase_in;
         rv_ff <= rv_in;
         total_ff <= total_in;
         if (do_upd) begin
            ltime_ff <= cur_ff.event_time;
            lsnd_ff <= cur_snd;
            ltgt_ff <= cur_tgt;
            have_ff <= 1'b1;
         end
      end
      rsp_ff <= rsp_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
      if (rd_phase_ff) begin
         den_ff <= den_c;
         bad_ff <= den_c[DB] || den_c == '0;
      end
   end

   // memories: read when start is high, written in the cycle after start
   always_ff @(posedge clock) begin
      if (st_ff == rpas_pkg::ST_CLEAR) begin
         out_mem[clr_ff[AW-1:0]] <= '0;
         in_mem[clr_ff[AW-1:0]] <= '0;
      end else if (start) begin
         cur_ff <= q_data;
         o_rd_ff <= out_mem[tgt];
         i_rd_ff <= in_mem[tgt];
         os_rd_ff <= out_mem[snd];
         eq_ff <= q_data.event_time == ltime_ff;
         have_snap_ff <= have_ff;
         lsnd_hit_ff <= lsnd_ff == tgt;
         ltgt_hit_ff <= ltgt_ff == tgt;
         tot_snap_ff <= total_ff;
      end else if (do_upd) begin
         if (cur_snd == cur_tgt) begin
            out_mem[cur_snd] <=
               (o_rd_ff != CMAX) ? o_rd_ff + 1'b1 : o_rd_ff;
         end else begin
            out_mem[cur_snd] <=
               (os_rd_ff != CMAX) ? os_rd_ff + 1'b1 : os_rd_ff;
         end
         in_mem[cur_tgt] <= (i_rd_ff != CMAX) ? i_rd_ff + 1'b1 : i_rd_ff;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff) else $error("result dropped");
   a_bad: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_ff.bad_denominator |-> rsp_ff.score == '0) else $error("bad score");
   a_clr: assert property (@(posedge clock) disable iff (reset)
      st_ff == rpas_pkg::ST_CLEAR |-> !q_take) else $error("take during clear");
endmodule

// ----- design/rem_pref_attach_stat_core.sv -----
// Flow: the count tables are read when the back starts a request and updated in
// the cycle after; the divider then runs COUNT_BITS+17 steps, and ST_OUTPUT loads
// the score into the result register. Requests are handled one at a time: no new
// request starts until the last one's result has been loaded, which waits while
// an earlier result is stalled.
// Reset: synchronous; afterwards a clearing pass zeroes all ACTORS entries of both
// count tables while no request is taken from the queue.
module rem_pref_attach_stat_core #(
   parameter int ACTORS = rpas_pkg::ACTORS_DEF,
   parameter int COUNT_BITS = rpas_pkg::COUNT_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  rpas_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rpas_pkg::rsp_type rsp_data
);
   logic q_valid, q_take;
   rpas_pkg::req_type q_data;

   // front: take request, fold ids, buffer
   rpas_front #(.ACTORS(ACTORS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_take, .q_data);

   // back: counts, score, result register
   rpas_back #(.ACTORS(ACTORS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_data,
      .rsp_valid, .rsp_stall, .rsp_data);
endmodule

// ----- test/rem_pref_attach_stat_core_test.sv -----
`timescale 1ns / 100ps

module rem_pref_attach_stat_core_test;

   localparam int COUNT_MAX = (1 << rpas_pkg::COUNT_BITS_DEF) - 1;
   localparam int SCORE_MAX = (1 << rpas_pkg::SCORE_BITS) - 1;
   // clearing pass, then the requests one at a time, long stalls, generous slack
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rpas_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rpas_pkg::rsp_type rsp_data;

   rem_pref_attach_stat_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // predictor state: per-actor counts and the last real event
   int unsigned sent_count[rpas_pkg::ACTORS_DEF];
   int unsigned recv_count[rpas_pkg::ACTORS_DEF];
   int unsigned real_events;
   logic [rpas_pkg::TIME_BITS-1:0] prev_time;
   logic [rpas_pkg::ID_BITS-1:0] prev_sender, prev_target;
   bit seen_event;

   rpas_pkg::rsp_type pending_scores[$];
   int errors = 0;
   int cycles = 0;
   bit hold_off = 1'b0;

   task automatic report(input string what, input rpas_pkg::rsp_type got,
                         input rpas_pkg::rsp_type want);
      $display("MISMATCH %s: got score=%0d bad=%0b, want score=%0d bad=%0b @%0t",
               what, got.score, got.bad_denominator, want.score,
               want.bad_denominator, $realtime);
      errors++;
   endtask

   function automatic int unsigned bump(input int unsigned c);
      return (c < COUNT_MAX) ? c + 1 : c;
   endfunction

   // Score one request against the counts so far, then count it unless it is control.
   function automatic void score_event(input rpas_pkg::req_type r);
      longint unsigned o, i, q;
      longint denom;
      rpas_pkg::rsp_type res;
      o = sent_count[r.target_id];
      i = recv_count[r.target_id];
      if (r.sampled) begin
         if (r.event_time == prev_time) begin
            denom = longint'(real_events) - 1;
            if (seen_event) begin
               if (prev_target == r.target_id && i > 0) i--;
               if (prev_sender == r.target_id && o > 0) o--;
            end
         end else begin
            denom = real_events;
         end
         if (denom <= 0) begin
            res.score = '0;
            res.bad_denominator = 1'b1;
         end else begin
            q = ((o + i) << rpas_pkg::FRAC_BITS) / (2 * longint'(denom));
            if (q > SCORE_MAX) q = SCORE_MAX;
            res.score = q[rpas_pkg::SCORE_BITS-1:0];
            res.bad_denominator = 1'b0;
         end
         pending_scores.push_back(res);
      end
      if (!r.control) begin
         sent_count[r.sender_id] = bump(sent_count[r.sender_id]);
         recv_count[r.target_id] = bump(recv_count[r.target_id]);
         real_events = bump(real_events);
         prev_time = r.event_time;
         prev_sender = r.sender_id;
         prev_target = r.target_id;
         seen_event = 1'b1;
      end
   endfunction

   // Directed table; fixed_want holds a hand-typed answer where has_want is set.
   typedef struct {
      rpas_pkg::req_type r;
      bit has_want;
      rpas_pkg::rsp_type want;
   } step_row;
   step_row directed[$];
   rpas_pkg::rsp_type fixed_want[$];

   function automatic rpas_pkg::req_type mk(bit s, bit c, logic [31:0] t, int snd, int tgt);
      rpas_pkg::req_type r;
      r.sampled = s; r.control = c; r.event_time = t;
      r.sender_id = rpas_pkg::ID_BITS'(snd); r.target_id = rpas_pkg::ID_BITS'(tgt);
      return r;
   endfunction

   function automatic void add(rpas_pkg::req_type r, bit hw = 0, rpas_pkg::rsp_type w = '0);
      step_row row;
      row.r = r; row.has_want = hw; row.want = w;
      directed.push_back(row);
   endfunction

   // result side: compare against the oldest expectation
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scores.size() == 0) begin
            report("unexpected result", rsp_data, '0);
         end else begin
            rpas_pkg::rsp_type want;
            want = pending_scores.pop_front();
            if (fixed_want.size() > 0 && fixed_want[0] !== '1) begin
               if (fixed_want[0] != want) report("table vs predictor", want, fixed_want[0]);
            end
            if (fixed_want.size() > 0) void'(fixed_want.pop_front());
            if (rsp_data.score !== want.score)
               report("score", rsp_data, want);
            else if (rsp_data.bad_denominator !== want.bad_denominator)
               report("bad_denominator", rsp_data, want);
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (cycles % 3000 < 1500) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // long hold-off well after the clearing pass, while requests keep coming
   initial begin
      repeat (3000) @(posedge clock);
      hold_off = 1'b1;
      repeat (600) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      @(posedge clock);
      while (cycles < CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // drive one request and wait for acceptance
   task automatic send(input rpas_pkg::req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      score_event(r);
   endtask

   task automatic idle_gap();
      int gap;
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      rpas_pkg::req_type r;
      rpas_pkg::rsp_type w;
      int actor_pool, burst;
      logic [31:0] now;
      real_events = 0; prev_time = '0; prev_sender = '0; prev_target = '0;
      seen_event = 0;
      foreach (sent_count[k]) begin
         sent_count[k] = 0;
         recv_count[k] = 0;
      end
      w.score = '0; w.bad_denominator = 1'b1;
      // before any real event: bad denominator, including time 0
      add(mk(1, 1, 0, 0, 0), 1, w);
      add(mk(1, 1, 32'hFFFF_FFFF, 1023, 1023), 1, w);
      add(mk(1, 0, 5, 1023, 1023));
      // equal time with total 1 gives denominator 0
      add(mk(1, 0, 5, 3, 1023), 1, w);
      add(mk(1, 0, 6, 1023, 1023));
      add(mk(1, 0, 6, 1023, 7));
      add(mk(1, 1, 6, 7, 1023));
      add(mk(1, 1, 7, 7, 1023));
      add(mk(0, 0, 7, 0, 1023));
      add(mk(0, 1, 8, 0, 0));
      add(mk(1, 0, 8, 1023, 1023));
      add(mk(1, 0, 8, 1023, 1023));
      add(mk(1, 0, 9, 1023, 1023));
      add(mk(1, 0, 32'hFFFF_FFFF, 512, 1023));
      add(mk(1, 0, 32'hFFFF_FFFF, 1023, 512));
      add(mk(1, 1, 32'hFFFF_FFFF, 1, 512));
      add(mk(1, 1, 32'h5555_AAAA, 341, 682));
      add(mk(1, 1, 32'hAAAA_5555, 682, 341));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[k]) begin
         if (directed[k].r.sampled)
            fixed_want.push_back(directed[k].has_want ? directed[k].want
                                                      : rpas_pkg::rsp_type'('1));
         send(directed[k].r);
         idle_gap();
      end

      // random: events mostly on a 16-actor pool, time mostly nondecreasing
      now = 32'hFFFF_FF00 - 32'd4000;
      for (int n = 0; n < 950; ) begin
         burst = $urandom_range(1, 20);
         actor_pool = ($urandom_range(0, 3) == 0) ? 1023 : 15;
         for (int b = 0; b < burst; b++, n++) begin
            case ($urandom_range(0, 3))
               0: now = now;
               1: now = now + 1;
               default: now = now + $urandom_range(0, 3);
            endcase
            r = mk($urandom_range(0, 3) != 0, $urandom_range(0, 7) == 0, now,
                   $urandom_range(0, actor_pool), $urandom_range(0, actor_pool));
            if ($urandom_range(0, 19) == 0) r.event_time = $urandom;
            if (r.sampled) fixed_want.push_back(rpas_pkg::rsp_type'('1));
            send(r);
         end
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b0;

      while (pending_scores.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
